@@ src/rmq_pkg.sv @@
package rmq_pkg;

  localparam int unsigned FRAC_BITS_DEF  = 14;
  localparam int unsigned ELEM_WIDTH_DEF = 16;

  // component that takes the root term
  typedef enum logic [1:0] {
    DOM_W = 2'd0,
    DOM_X = 2'd1,
    DOM_Y = 2'd2,
    DOM_Z = 2'd3
  } dom_e;

  typedef struct packed {
    logic       valid;
    logic       bad;
    dom_e       dom;
    logic [2:0] neg;
  } ctl_t;

endpackage

@@ src/rmq_prep.sv @@
module rmq_prep #(
  parameter int unsigned ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
  localparam int unsigned E   = ELEM_WIDTH,
  localparam int unsigned F   = FRAC_BITS,
  localparam int unsigned RW  = ((E > F + 1) ? E : F + 1) + 3,
  localparam int unsigned NW0 = RW - 1 + F,
  localparam int unsigned NW  = NW0 + (NW0 % 2)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [9*E-1:0]        elem_i,
  output rmq_pkg::ctl_t         ctl_q,
  output logic [NW-1:0]         n_q,
  output logic [3*(E+1)-1:0]    mag_q
);
  import rmq_pkg::*;

  localparam logic signed [RW-1:0] ONE = RW'(1) << F;

  logic signed [RW-1:0] m [9];
  logic signed [RW-1:0] tr, rad;
  logic signed [RW-1:0] num [3];
  ctl_t                 ctl_d;
  logic [NW-1:0]        n_d;
  logic [3*(E+1)-1:0]   mag_d;
  logic [1:0]           ax;
  logic [RW-1:0]        ab;

  always_comb begin
    for (int x = 0; x < 9; x++) begin
      m[x] = {{(RW-E){elem_i[x*E+E-1]}}, elem_i[x*E +: E]};
    end
  end

  always_comb begin
    ctl_d = '0;
    ctl_d.valid = valid_i;
    ax  = 2'd0;
    tr  = m[0] + m[4] + m[8];
    rad = '0;
    num[0] = '0;
    num[1] = '0;
    num[2] = '0;
    if (!tr[RW-1] && (tr != '0)) begin
      ctl_d.dom = DOM_W;
      rad    = tr + ONE;
      num[0] = m[7] - m[5];
      num[1] = m[2] - m[6];
      num[2] = m[3] - m[1];
    end else begin
      if (m[4] > m[0]) ax = 2'd1;
      if (m[8] > ((ax == 2'd1) ? m[4] : m[0])) ax = 2'd2;
      unique case (ax)
        2'd0: begin
          ctl_d.dom = DOM_X;
          rad    = m[0] - m[4] - m[8] + ONE;
          num[0] = m[7] - m[5];
          num[1] = m[3] + m[1];
          num[2] = m[6] + m[2];
        end
        2'd1: begin
          ctl_d.dom = DOM_Y;
          rad    = m[4] - m[8] - m[0] + ONE;
          num[0] = m[2] - m[6];
          num[1] = m[7] + m[5];
          num[2] = m[1] + m[3];
        end
        default: begin
          ctl_d.dom = DOM_Z;
          rad    = m[8] - m[0] - m[4] + ONE;
          num[0] = m[3] - m[1];
          num[1] = m[2] + m[6];
          num[2] = m[5] + m[7];
        end
      endcase
    end
    ctl_d.bad = rad[RW-1] || (rad == '0);
    n_d = ctl_d.bad ? '0 : NW'({rad[RW-2:0], {F{1'b0}}});
    for (int l = 0; l < 3; l++) begin
      ctl_d.neg[l] = num[l][RW-1];
      ab = num[l][RW-1] ? (RW'(0) - num[l]) : num[l];
      mag_d[l*(E+1) +: (E+1)] = ab[E:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q   <= n_d;
      mag_q <= mag_d;
    end
  end

endmodule

@@ src/rmq_sqrt_stage.sv @@
module rmq_sqrt_stage #(
  parameter int unsigned ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
  localparam int unsigned E   = ELEM_WIDTH,
  localparam int unsigned F   = FRAC_BITS,
  localparam int unsigned RW  = ((E > F + 1) ? E : F + 1) + 3,
  localparam int unsigned NW0 = RW - 1 + F,
  localparam int unsigned NW  = NW0 + (NW0 % 2),
  localparam int unsigned QW  = NW / 2,
  localparam int unsigned PW  = 3 * (E + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  rmq_pkg::ctl_t  ctl_i,
  input  logic [QW+1:0]  rem_i,
  input  logic [QW-1:0]  root_i,
  input  logic [NW-1:0]  n_i,
  input  logic [PW-1:0]  pass_i,
  output rmq_pkg::ctl_t  ctl_q,
  output logic [QW+1:0]  rem_q,
  output logic [QW-1:0]  root_q,
  output logic [NW-1:0]  n_q,
  output logic [PW-1:0]  pass_q
);
  import rmq_pkg::*;

  logic [QW+3:0] trial, test, diff;
  logic [QW+1:0] rem_d;
  logic [QW-1:0] root_d;

  // one root bit per stage
  always_comb begin
    trial = {rem_i, n_i[NW-1 -: 2]};
    test  = {2'b00, root_i, 2'b01};
    diff  = trial - test;
    if (trial >= test) begin
      rem_d  = diff[QW+1:0];
      root_d = {root_i[QW-2:0], 1'b1};
    end else begin
      rem_d  = trial[QW+1:0];
      root_d = {root_i[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      n_q    <= {n_i[NW-3:0], 2'b00};
      pass_q <= pass_i;
    end
  end

endmodule

@@ src/rmq_div_stage.sv @@
module rmq_div_stage #(
  parameter int unsigned ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
  localparam int unsigned E   = ELEM_WIDTH,
  localparam int unsigned F   = FRAC_BITS,
  localparam int unsigned RW  = ((E > F + 1) ? E : F + 1) + 3,
  localparam int unsigned NW0 = RW - 1 + F,
  localparam int unsigned NW  = NW0 + (NW0 % 2),
  localparam int unsigned QW  = NW / 2,
  localparam int unsigned SW  = QW + 1,
  localparam int unsigned DW  = E + 1 + F
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rmq_pkg::ctl_t   ctl_i,
  input  logic [SW-1:0]   s_i,
  input  logic [QW-2:0]   half_i,
  input  logic [3*SW-1:0] rem_i,
  input  logic [3*DW-1:0] dq_i,
  output rmq_pkg::ctl_t   ctl_q,
  output logic [SW-1:0]   s_q,
  output logic [QW-2:0]   half_q,
  output logic [3*SW-1:0] rem_q,
  output logic [3*DW-1:0] dq_q
);
  import rmq_pkg::*;

  logic [SW:0]     t, df;
  logic [DW-1:0]   dq;
  logic [3*SW-1:0] rem_d;
  logic [3*DW-1:0] dq_d;

  // one quotient bit per stage on each of the three lanes
  always_comb begin
    t  = '0;
    df = '0;
    dq = '0;
    for (int l = 0; l < 3; l++) begin
      dq = dq_i[l*DW +: DW];
      t  = {rem_i[l*SW +: SW], dq[DW-1]};
      df = t - {1'b0, s_i};
      if (t >= {1'b0, s_i}) begin
        rem_d[l*SW +: SW] = df[SW-1:0];
        dq_d[l*DW +: DW]  = {dq[DW-2:0], 1'b1};
      end else begin
        rem_d[l*SW +: SW] = t[SW-1:0];
        dq_d[l*DW +: DW]  = {dq[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q    <= s_i;
      half_q <= half_i;
      rem_q  <= rem_d;
      dq_q   <= dq_d;
    end
  end

endmodule

@@ src/rmq_post.sv @@
module rmq_post #(
  parameter int unsigned ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
  localparam int unsigned E   = ELEM_WIDTH,
  localparam int unsigned F   = FRAC_BITS,
  localparam int unsigned RW  = ((E > F + 1) ? E : F + 1) + 3,
  localparam int unsigned NW0 = RW - 1 + F,
  localparam int unsigned NW  = NW0 + (NW0 % 2),
  localparam int unsigned QW  = NW / 2,
  localparam int unsigned DW  = E + 1 + F,
  localparam int unsigned CW  = DW + QW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rmq_pkg::ctl_t   ctl_i,
  input  logic [QW-2:0]   half_i,
  input  logic [3*DW-1:0] quo_i,
  output logic            valid_q,
  output logic            bad_q,
  output logic [4*E-1:0]  quat_q
);
  import rmq_pkg::*;

  localparam logic [CW-1:0] LIM_P = (CW'(1) << (E - 1)) - CW'(1);
  localparam logic [CW-1:0] LIM_N = CW'(1) << (E - 1);
  localparam logic [E-1:0]  MAX_V = LIM_P[E-1:0];
  localparam logic [E-1:0]  MIN_V = LIM_N[E-1:0];

  logic [CW-1:0]  mag;
  logic [E-1:0]   p [3];
  logic [E-1:0]   hv;
  logic [4*E-1:0] quat_d;

  always_comb begin
    mag = '0;
    for (int l = 0; l < 3; l++) begin
      mag = CW'(quo_i[l*DW +: DW]);
      if (!ctl_i.neg[l]) begin
        p[l] = (mag > LIM_P) ? MAX_V : mag[E-1:0];
      end else begin
        p[l] = (mag > LIM_N) ? MIN_V : (E'(0) - mag[E-1:0]);
      end
    end
    hv = (CW'(half_i) > LIM_P) ? MAX_V : E'(half_i);
    // word order w, x, y, z from the low end
    case (ctl_i.dom)
      DOM_W:   quat_d = {p[2], p[1], p[0], hv};
      DOM_X:   quat_d = {p[2], p[1], hv, p[0]};
      DOM_Y:   quat_d = {p[1], hv, p[2], p[0]};
      default: quat_d = {hv, p[1], p[0], p[0]};
    endcase
    if (ctl_i.dom == DOM_Z) begin
      quat_d = {hv, p[2], p[1], p[0]};
    end
    if (ctl_i.bad) begin
      quat_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bad_q  <= ctl_i.bad;
      quat_q <= quat_d;
    end
  end

endmodule

@@ src/rotation_matrix_to_quaternion_top.sv @@
// Converts one 3x3 rotation matrix (nine signed Q1.14 words) into a unit
// quaternion w, x, y, z by Shepperd's method, taking one matrix per clock.
// The pipeline is one prep stage, a bit-per-stage square root over R root
// bits (16 at the default widths), three bit-per-stage restoring dividers in
// parallel over D = ELEM_WIDTH + 1 + FRAC_BITS quotient bits (31 by
// default), and the saturating output register. The whole pipeline holds
// while the output word is stalled. Square root and quotients truncate;
// bad_input on tuser flags a nonpositive radicand and forces all
// components to zero.
module rotation_matrix_to_quaternion_top #(
  parameter int unsigned ELEM_WIDTH = rmq_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
  localparam int unsigned E     = ELEM_WIDTH,
  localparam int unsigned IN_W  = ((9 * E + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * E + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // qw, qx, qy, qz
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // bad_input
  output logic             m_axis_tuser_o
);
  import rmq_pkg::*;

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned RW  = ((E > F + 1) ? E : F + 1) + 3;
  localparam int unsigned NW0 = RW - 1 + F;
  localparam int unsigned NW  = NW0 + (NW0 % 2);
  localparam int unsigned QW  = NW / 2;
  localparam int unsigned SW  = QW + 1;
  localparam int unsigned DW  = E + 1 + F;
  localparam int unsigned PW  = 3 * (E + 1);

  logic en;

  ctl_t          sq_ctl  [QW+1];
  logic [QW+1:0] sq_rem  [QW+1];
  logic [QW-1:0] sq_root [QW+1];
  logic [NW-1:0] sq_n    [QW+1];
  logic [PW-1:0] sq_pass [QW+1];

  ctl_t            dv_ctl  [DW+1];
  logic [SW-1:0]   dv_s    [DW+1];
  logic [QW-2:0]   dv_half [DW+1];
  logic [3*SW-1:0] dv_rem  [DW+1];
  logic [3*DW-1:0] dv_dq   [DW+1];

  logic           out_valid, out_bad;
  logic [4*E-1:0] out_quat;

  assign en = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = en;

  rmq_prep #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .elem_i  (s_axis_tdata_i[9*E-1:0]),
    .ctl_q   (sq_ctl[0]),
    .n_q     (sq_n[0]),
    .mag_q   (sq_pass[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_sqrt
    rmq_sqrt_stage #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (sq_ctl[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .n_i    (sq_n[g]),
      .pass_i (sq_pass[g]),
      .ctl_q  (sq_ctl[g+1]),
      .rem_q  (sq_rem[g+1]),
      .root_q (sq_root[g+1]),
      .n_q    (sq_n[g+1]),
      .pass_q (sq_pass[g+1])
    );
  end

  assign dv_ctl[0]  = sq_ctl[QW];
  assign dv_s[0]    = {sq_root[QW], 1'b0};
  assign dv_half[0] = sq_root[QW][QW-1:1];
  assign dv_rem[0]  = '0;

  for (genvar l = 0; l < 3; l++) begin : g_dvd
    assign dv_dq[0][l*DW +: DW] = {sq_pass[QW][l*(E+1) +: (E+1)], {F{1'b0}}};
  end

  for (genvar g = 0; g < DW; g++) begin : g_div
    rmq_div_stage #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (dv_ctl[g]),
      .s_i    (dv_s[g]),
      .half_i (dv_half[g]),
      .rem_i  (dv_rem[g]),
      .dq_i   (dv_dq[g]),
      .ctl_q  (dv_ctl[g+1]),
      .s_q    (dv_s[g+1]),
      .half_q (dv_half[g+1]),
      .rem_q  (dv_rem[g+1]),
      .dq_q   (dv_dq[g+1])
    );
  end

  rmq_post #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (dv_ctl[DW]),
    .half_i  (dv_half[DW]),
    .quo_i   (dv_dq[DW]),
    .valid_q (out_valid),
    .bad_q   (out_bad),
    .quat_q  (out_quat)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = OUT_W'(out_quat);
  assign m_axis_tuser_o  = out_bad;

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o == '0))
    else $error("bad_input word carries nonzero components");

  a_good_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (m_axis_tdata_o != '0))
    else $error("valid quaternion is all zero");

  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_ctl[0].valid && !dv_ctl[0].bad |-> (dv_s[0] != '0))
    else $error("zero divisor on a good word");

endmodule

@@ tb/tb_top.sv @@
module tb_top;

  localparam int unsigned EW = rmq_pkg::ELEM_WIDTH_DEF;
  localparam int unsigned FB = rmq_pkg::FRAC_BITS_DEF;
  localparam int unsigned IN_W = ((9 * EW + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((4 * EW + 7) / 8) * 8;
  localparam int LATENCY = 49;
  localparam int N_RANDOM = 1830;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] qw;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic        bad;
  } quat_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [IN_W-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  rotation_matrix_to_quaternion_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o),
    .m_axis_tuser_o(m_axis_tuser_o)
  );

  logic [IN_W-1:0] matrix_q[$];
  quat_t quat_exp_q[$];
  int errors;
  int n_sent;
  int n_checked;
  int n_bad;
  longint cycles;
  bit hold_send;
  bit calm;
  bit in_acc;
  int send_gap;
  int recv_gap;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint isqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint quot_trunc(longint d, longint s);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? -d : d;
    q = (mag << FB) / s;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic quat_t matrix_to_quat(logic [IN_W-1:0] d);
    longint m[3][3];
    longint q[4];
    longint tr;
    longint rad;
    longint root;
    longint s;
    int i;
    int j;
    int k;
    quat_t r;
    for (int a = 0; a < 9; a++) m[a / 3][a % 3] = longint'($signed(d[a*16 +: 16]));
    for (int a = 0; a < 4; a++) q[a] = 0;
    r.bad = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      root = isqrt((tr + (64'sd1 << FB)) << FB);
      s = root * 2;
      q[0] = root >> 1;
      q[1] = quot_trunc(m[2][1] - m[1][2], s);
      q[2] = quot_trunc(m[0][2] - m[2][0], s);
      q[3] = quot_trunc(m[1][0] - m[0][1], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + (64'sd1 << FB);
      if (rad <= 0) begin
        r.bad = 1'b1;
      end else begin
        root = isqrt(rad << FB);
        s = root * 2;
        q[0] = quot_trunc(m[k][j] - m[j][k], s);
        q[1 + i] = root >> 1;
        q[1 + j] = quot_trunc(m[j][i] + m[i][j], s);
        q[1 + k] = quot_trunc(m[k][i] + m[i][k], s);
      end
    end
    r.qw = sat16(q[0]);
    r.qx = sat16(q[1]);
    r.qy = sat16(q[2]);
    r.qz = sat16(q[3]);
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_matrix(int e[9]);
    logic [IN_W-1:0] d;
    d = '0;
    for (int a = 0; a < 9; a++) d[a*16 +: 16] = e[a][15:0];
    return d;
  endfunction

  function automatic logic [IN_W-1:0] random_matrix();
    int e[9];
    int c;
    int ct;
    int st;
    int ax;
    c = $urandom_range(0, 9);
    if (c < 3) begin
      for (int a = 0; a < 9; a++) e[a] = $urandom_range(0, 65535);
    end else if (c < 5) begin
      for (int a = 0; a < 9; a++) e[a] = int'($urandom_range(0, 4000)) - 2000;
      ax = $urandom_range(0, 2);
      for (int a = 0; a < 3; a++)
        e[a*4] = (a == ax) ? int'($urandom_range(0, 16384)) : -int'($urandom_range(0, 16384));
    end else begin
      // near-rotation about a random axis, random angle
      ct = int'($urandom_range(0, 32768)) - 16384;
      st = int'($urandom_range(0, 32768)) - 16384;
      ax = $urandom_range(0, 2);
      for (int a = 0; a < 9; a++) e[a] = int'($urandom_range(0, 64)) - 32;
      e[ax*4] = 16384;
      e[((ax+1)%3)*4] = ct;
      e[((ax+2)%3)*4] = ct;
      e[((ax+1)%3)*3 + (ax+2)%3] = -st;
      e[((ax+2)%3)*3 + (ax+1)%3] = st;
    end
    return pack_matrix(e);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch word %0d %s: got %h want %h", n_checked, what, got, want);
    errors++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_acc) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 9);
          s_axis_tvalid_i <= 1'b0;
        end else if (matrix_q.size() > 0 && !hold_send) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= matrix_q[0];
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(1, 9);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    quat_t got;
    quat_t want;
    cycles++;
    in_acc = s_axis_tvalid_i && s_axis_tready_o;
    if (in_acc) begin
      quat_exp_q.push_back(matrix_to_quat(s_axis_tdata_i));
      void'(matrix_q.pop_front());
      n_sent++;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.qw = m_axis_tdata_o[15:0];
      got.qx = m_axis_tdata_o[31:16];
      got.qy = m_axis_tdata_o[47:32];
      got.qz = m_axis_tdata_o[63:48];
      got.bad = m_axis_tuser_o;
      if (quat_exp_q.size() == 0) begin
        report("unexpected word", m_axis_tdata_o[15:0], 16'h0000);
      end else begin
        want = quat_exp_q.pop_front();
        if (got.qw !== want.qw) report("qw", got.qw, want.qw);
        if (got.qx !== want.qx) report("qx", got.qx, want.qx);
        if (got.qy !== want.qy) report("qy", got.qy, want.qy);
        if (got.qz !== want.qz) report("qz", got.qz, want.qz);
        if (got.bad !== want.bad) report("bad_input", {15'd0, got.bad}, {15'd0, want.bad});
        if (want.bad) n_bad++;
        n_checked++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int e[9];
    int one;
    one = 16384;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_bad = 0;
    cycles = 0;
    hold_send = 1'b0;
    calm = 1'b0;
    in_acc = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;

    e = '{one, 0, 0, 0, one, 0, 0, 0, one};
    matrix_q.push_back(pack_matrix(e));
    e = '{one, 0, 0, 0, -one, 0, 0, 0, -one};
    matrix_q.push_back(pack_matrix(e));
    e = '{-one, 0, 0, 0, one, 0, 0, 0, -one};
    matrix_q.push_back(pack_matrix(e));
    e = '{-one, 0, 0, 0, -one, 0, 0, 0, one};
    matrix_q.push_back(pack_matrix(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    matrix_q.push_back(pack_matrix(e));
    e = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};
    matrix_q.push_back(pack_matrix(e));
    e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
    matrix_q.push_back(pack_matrix(e));
    e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    matrix_q.push_back(pack_matrix(e));
    e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    matrix_q.push_back(pack_matrix(e));
    e = '{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
    matrix_q.push_back(pack_matrix(e));
    e = '{-1, 32767, 32767, 32767, -1, 32767, 32767, 32767, -1};
    matrix_q.push_back(pack_matrix(e));
    e = '{-32768, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768};
    matrix_q.push_back(pack_matrix(e));
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 1};
    matrix_q.push_back(pack_matrix(e));
    e = '{-5, 0, 0, 0, -5, 0, 0, 0, -5};
    matrix_q.push_back(pack_matrix(e));
    e = '{0, 0, 0, 0, -one, 0, 0, 0, -one};
    matrix_q.push_back(pack_matrix(e));
    e = '{-32768, 0, 0, 0, 32767, 0, 0, 0, 32767};
    matrix_q.push_back(pack_matrix(e));
    e = '{32767, 0, 0, 0, -32768, 0, 0, 0, -32768};
    matrix_q.push_back(pack_matrix(e));
    e = '{0, -one, 0, one, 0, 0, 0, 0, one};
    matrix_q.push_back(pack_matrix(e));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (matrix_q.size() == 0);
    hold_send = 1'b1;
    wait (quat_exp_q.size() == 0 && !s_axis_tvalid_i);
    hold_send = 1'b0;

    for (int a = 0; a < N_RANDOM; a++) begin
      if (a == N_RANDOM - 200) begin
        wait (matrix_q.size() == 0);
        calm = 1'b1;
      end
      matrix_q.push_back(random_matrix());
      if (a == N_RANDOM / 2) begin
        wait (matrix_q.size() == 0);
        hold_send = 1'b1;
        wait (quat_exp_q.size() == 0 && !s_axis_tvalid_i);
        hold_send = 1'b0;
      end
    end

    wait (matrix_q.size() == 0 && !s_axis_tvalid_i);
    wait (quat_exp_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("%0d matrices sent, %0d quaternions checked, %0d flagged bad input",
             n_sent, n_checked, n_bad);
    $display("directed diagonal cases, saturation corners, random and rotation-like matrices");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rmq_pkg.sv
src/rmq_prep.sv
src/rmq_sqrt_stage.sv
src/rmq_div_stage.sv
src/rmq_post.sv
src/rotation_matrix_to_quaternion_top.sv
tb/tb_top.sv
